// ----- rtl/spse_pkg.sv -----
// ----------------------------------------------------------------------------
// spse_pkg
// Shared types, codes and command/status structs for the sparse polynomial
// store and evaluator.
// ----------------------------------------------------------------------------
package spse_pkg;

  localparam int unsigned NumPolysDef = 8;
  localparam int unsigned MaxTermsDef = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_ADD    = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNDEF      = 2'd1,
    ST_NAMES_FULL = 2'd2,
    ST_TERMS_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  poly_name;
    logic [31:0] term_coef;
    logic [4:0]  term_expo;
    logic [31:0] eval_point;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } out_item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;        // capture input item, resolve name lookup
    logic create;      // apply create
    logic rd_issue;    // issue term memory read at scan index
    logic rd_prev;     // issue term memory read at scan index - 1
    logic scan_clr;    // clear scan index
    logic scan_top;    // load scan index with term count
    logic scan_inc;    // advance scan index
    logic scan_dec;    // step scan index down
    logic pow_start;   // begin power iteration on read data
    logic pow_step;    // one multiply of power iteration
    logic term_mul;    // coef * power
    logic acc_add;     // accumulate product
    logic pos_set;     // latch insertion position from scan index
    logic merge_wr;    // write merged coefficient at pos
    logic shift_wr;    // write read entry at scan index (insert)
    logic shift_dn;    // write read entry at scan index - 1 (remove)
    logic ins_wr;      // write new term at pos
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;    // capture result
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic       found;
    logic       free_avail;
    logic       scan_done;   // scan index reached count
    logic       scan_zero;   // scan index at pos (insert shift end)
    logic       rd_gt;       // read exponent greater than new exponent
    logic       rd_eq;       // read exponent equal
    logic       sum_zero;    // merged sum is zero
    logic       full;        // count at capacity
    logic       pow_done;
    logic       rm_done;     // removal shift reached end
  } stat_t;

endpackage

// ----- rtl/spse_if.sv -----
// ----------------------------------------------------------------------------
// spse_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface spse_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/spse_ctrl.sv -----
// ----------------------------------------------------------------------------
// spse_ctrl
// Sequencer for create, add and evaluate items. Drives the datapath by
// commands and follows its status flags.
// ----------------------------------------------------------------------------
module spse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  logic            out_valid_q_i,
  input  logic            out_ready_i,
  input  spse_pkg::stat_t stat_i,
  output spse_pkg::cmd_t  cmd_o,
  output logic [1:0]      res_status_o
);
  import spse_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_CMP  = 4'd3;
  localparam logic [3:0] S_A_MRG  = 4'd4;
  localparam logic [3:0] S_R_RD   = 4'd5;
  localparam logic [3:0] S_R_WR   = 4'd6;
  localparam logic [3:0] S_I_RD   = 4'd7;
  localparam logic [3:0] S_I_WR   = 4'd8;
  localparam logic [3:0] S_E_RD   = 4'd9;
  localparam logic [3:0] S_E_POW  = 4'd10;
  localparam logic [3:0] S_E_MUL  = 4'd11;
  localparam logic [3:0] S_E_ACC  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [1:0] st_q, st_d;

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = in_op_i;
          st_d       = ST_OK;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.scan_clr = 1'b1;
        case (op_q)
          OP_CREATE: begin
            if (stat_i.found || stat_i.free_avail) begin
              cmd_o.create = 1'b1;
            end else begin
              st_d = ST_NAMES_FULL;
            end
            state_d = S_DONE;
          end
          OP_ADD: begin
            if (!stat_i.found) begin
              st_d    = ST_UNDEF;
              state_d = S_DONE;
            end else begin
              state_d = S_A_RD;
            end
          end
          OP_EVAL: begin
            if (!stat_i.found) begin
              st_d    = ST_UNDEF;
              state_d = S_DONE;
            end else begin
              state_d = S_E_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_A_RD: begin
        if (stat_i.scan_done) begin
          cmd_o.pos_set = 1'b1;
          state_d       = S_A_MRG;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (stat_i.rd_gt) begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_A_RD;
        end else begin
          cmd_o.pos_set = 1'b1;
          state_d       = S_A_MRG;
        end
      end
      S_A_MRG: begin
        // scan index equals pos; rd_eq valid only if pos < count
        if (!stat_i.scan_done && stat_i.rd_eq) begin
          cmd_o.merge_wr = 1'b1;
          if (stat_i.sum_zero) begin
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.scan_inc = 1'b1;
            state_d        = S_R_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.full) begin
          st_d    = ST_TERMS_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_top = 1'b1;
          state_d        = S_I_RD;
        end
      end
      S_R_RD: begin
        if (stat_i.rm_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_R_WR;
        end
      end
      S_R_WR: begin
        cmd_o.shift_dn = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = S_R_RD;
      end
      S_I_RD: begin
        // walk down from count to pos, moving each term up one place
        if (stat_i.scan_zero) begin
          cmd_o.ins_wr  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_I_WR;
        end
      end
      S_I_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.scan_dec = 1'b1;
        state_d        = S_I_RD;
      end
      S_E_RD: begin
        if (stat_i.scan_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_E_POW;
        end
      end
      S_E_POW: begin
        cmd_o.pow_start = 1'b1;
        state_d         = S_E_MUL;
      end
      S_E_MUL: begin
        if (stat_i.pow_done) begin
          cmd_o.term_mul = 1'b1;
          state_d        = S_E_ACC;
        end else begin
          cmd_o.pow_step = 1'b1;
        end
      end
      S_E_ACC: begin
        cmd_o.acc_add  = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = S_E_RD;
      end
      S_DONE: begin
        if (!out_valid_q_i || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/spse_dp.sv -----
// ----------------------------------------------------------------------------
// spse_dp
// Datapath: name table, term memory, scan index, power/multiply unit,
// accumulator and output register.
// ----------------------------------------------------------------------------
module spse_dp #(
  parameter int unsigned NumPolys = spse_pkg::NumPolysDef,
  parameter int unsigned MaxTerms = spse_pkg::MaxTermsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spse_pkg::in_item_t  in_item_i,
  input  spse_pkg::cmd_t      cmd_i,
  output spse_pkg::stat_t     stat_o,
  input  logic [1:0]          res_status_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output spse_pkg::out_item_t out_item_o
);
  import spse_pkg::*;

  localparam int unsigned SW = (NumPolys > 1) ? $clog2(NumPolys) : 1;
  localparam int unsigned CW = $clog2(MaxTerms + 1);
  localparam int unsigned Depth = NumPolys * MaxTerms;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CW-1:0] CntMax = CW'(MaxTerms);

  logic [7:0]    name_q  [NumPolys];
  logic          used_q  [NumPolys];
  logic [CW-1:0] count_q [NumPolys];

  logic [31:0] mem_coef [Depth];
  logic [4:0]  mem_expo [Depth];

  in_item_t    item_q;
  logic [SW-1:0] slot_q, hit_idx, free_idx;
  logic        found_q, hit, free_any;
  logic [CW-1:0] idx_q, pos_q, cnt_cur;
  logic [31:0] rd_coef_q;
  logic [4:0]  rd_expo_q;
  logic [31:0] pow_q, prod_q, acc_q;
  logic [4:0]  pow_cnt_q;
  logic [31:0] sum;
  logic        out_valid_q;
  out_item_t   out_q;
  logic [AW-1:0] base, a_rd, a_wr;
  logic [31:0] w_coef;
  logic [4:0]  w_expo;
  logic        w_en;
  logic        free_q;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = NumPolys - 1; s >= 0; s--) begin
      if (used_q[s] && name_q[s] == in_item_i.poly_name) begin
        hit = 1'b1;
        hit_idx = SW'(s);
      end
      if (!used_q[s]) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  assign cnt_cur = count_q[slot_q];
  assign base    = AW'(slot_q) * AW'(MaxTerms);
  assign sum     = rd_coef_q + item_q.term_coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumPolys; s++) begin
        name_q[s]  <= '0;
        used_q[s]  <= 1'b0;
        count_q[s] <= '0;
      end
      found_q <= 1'b0;
      slot_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        found_q <= hit;
        slot_q  <= hit ? hit_idx : free_idx;
      end
      if (cmd_i.create) begin
        used_q[slot_q]  <= 1'b1;
        name_q[slot_q]  <= item_q.poly_name;
        count_q[slot_q] <= '0;
      end
      if (cmd_i.cnt_inc) count_q[slot_q] <= cnt_cur + CW'(1);
      if (cmd_i.cnt_dec) count_q[slot_q] <= cnt_cur - CW'(1);
    end
  end

  // Load item, free flag sampled at load.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
      free_q <= free_any;
    end
  end

  // Scan index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.pos_set)  pos_q <= idx_q;
      if (cmd_i.scan_clr) idx_q <= '0;
      if (cmd_i.scan_top) idx_q <= cnt_cur;
      if (cmd_i.scan_inc) idx_q <= idx_q + CW'(1);
      if (cmd_i.scan_dec) idx_q <= idx_q - CW'(1);
    end
  end

  // Memory addressing.
  always_comb begin
    a_rd   = base + AW'(idx_q);
    w_en   = 1'b0;
    a_wr   = base + AW'(pos_q);
    w_coef = rd_coef_q;
    w_expo = rd_expo_q;
    if (cmd_i.rd_prev) a_rd = base + AW'(idx_q - CW'(1));
    if (cmd_i.merge_wr) begin
      w_en = 1'b1; w_coef = sum; w_expo = rd_expo_q;
    end
    if (cmd_i.shift_wr) begin
      w_en = 1'b1; a_wr = base + AW'(idx_q);
    end
    if (cmd_i.shift_dn) begin
      w_en = 1'b1; a_wr = base + AW'(idx_q - CW'(1));
    end
    if (cmd_i.ins_wr) begin
      w_en = 1'b1; w_coef = item_q.term_coef; w_expo = item_q.term_expo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_en) begin
      mem_coef[a_wr] <= w_coef;
      mem_expo[a_wr] <= w_expo;
    end
    if (cmd_i.rd_issue || cmd_i.rd_prev) begin
      rd_coef_q <= mem_coef[a_rd];
      rd_expo_q <= mem_expo[a_rd];
    end
  end

  // Power and product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) acc_q <= '0;
    if (cmd_i.pow_start) begin
      pow_q     <= 32'd1;
      pow_cnt_q <= rd_expo_q;
    end
    if (cmd_i.pow_step) begin
      pow_q     <= pow_q * item_q.eval_point;
      pow_cnt_q <= pow_cnt_q - 5'd1;
    end
    if (cmd_i.term_mul) prod_q <= rd_coef_q * pow_q;
    if (cmd_i.acc_add)  acc_q  <= acc_q + prod_q;
  end

  always_comb begin
    stat_o            = '0;
    stat_o.found      = found_q;
    stat_o.free_avail = free_q;
    stat_o.scan_done  = (idx_q >= cnt_cur);
    stat_o.scan_zero  = (idx_q == pos_q);
    stat_o.rd_gt      = (rd_expo_q > item_q.term_expo);
    stat_o.rd_eq      = (rd_expo_q == item_q.term_expo);
    stat_o.sum_zero   = (sum == 32'd0);
    stat_o.full       = (cnt_cur >= CntMax);
    stat_o.pow_done   = (pow_cnt_q == 5'd0);
    stat_o.rm_done    = (idx_q > cnt_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status <= res_status_i;
      out_q.value  <= (item_q.operation == OP_EVAL && res_status_i == ST_OK) ?
                      acc_q : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/sparse_polynomial_store_eval_core.sv -----
// ----------------------------------------------------------------------------
// sparse_polynomial_store_eval_core
// Store of named sparse integer polynomials with add-term and evaluate.
// ----------------------------------------------------------------------------
// One item at a time; an item is taken only while the block is idle. Create,
// an unknown name and operation three go from dispatch straight to the
// result. Add scans the slot's terms, reading and comparing each in turn,
// then shifts the tail up or down one term at a time through the term
// memory, with a read state and a write state per term. Evaluate raises the
// point to each term's exponent e by e iterative multiplies, then scales by
// the coefficient and accumulates; exponents in a list are distinct. The
// result sits in an output register; the next item is taken once it has been
// loaded there, so a stalled result holds the input off.
module sparse_polynomial_store_eval_core #(
  parameter int unsigned NumPolys = spse_pkg::NumPolysDef,
  parameter int unsigned MaxTerms = spse_pkg::MaxTermsDef
) (
  input logic clk_i,
  input logic rst_ni,
  spse_if.sink   in_if,
  spse_if.source out_if
);
  import spse_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [1:0] res_status;
  in_item_t in_item;
  out_item_t out_item;

  assign in_item     = in_if.data;
  assign out_if.data = out_item;

  spse_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i    (in_if.valid),
    .in_ready_o    (in_if.ready),
    .in_op_i       (in_item.operation),
    .out_valid_q_i (out_if.valid),
    .out_ready_i   (out_if.ready),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .res_status_o  (res_status)
  );

  spse_dp #(.NumPolys(NumPolys), .MaxTerms(MaxTerms)) u_dp (
    .clk_i,
    .rst_ni,
    .in_item_i    (in_item),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_status_i (res_status),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .out_item_o   (out_item)
  );

endmodule

// ----- rtl/spse_chk.sv -----
// ----------------------------------------------------------------------------
// spse_chk
// Port-level checks on item and result transfers.
// ----------------------------------------------------------------------------
module spse_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [33:0] out_data_i
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transfer taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i || !$rose(out_valid_i))
    else $error("result without work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i[1:0] != 2'd0 |-> out_data_i[33:2] == 32'd0)
    else $error("nonzero value with error status");
endmodule

bind sparse_polynomial_store_eval_core spse_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

// ----- sim/sparse_polynomial_store_eval_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_polynomial_store_eval_core_checker
// Watches the item and result channels of the polynomial store. It keeps its
// own copy of the named slots and term lists, works out the value and status
// of every accepted item and compares each result with the oldest one due.
// ----------------------------------------------------------------------------
module sparse_polynomial_store_eval_core_checker #(
  parameter int unsigned NumPolys = spse_pkg::NumPolysDef,
  parameter int unsigned MaxTerms = spse_pkg::MaxTermsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  spse_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  spse_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import spse_pkg::*;

  logic [7:0]  name_q  [NumPolys];
  logic        used_q  [NumPolys];
  int          count_q [NumPolys];
  logic [31:0] coef_q  [NumPolys][MaxTerms];
  logic [4:0]  expo_q  [NumPolys][MaxTerms];
  out_item_t   due_results [$];

  function automatic int find_slot(logic [7:0] nm);
    for (int s = 0; s < NumPolys; s++) begin
      if (used_q[s] && name_q[s] == nm) return s;
    end
    return -1;
  endfunction

  function automatic logic [31:0] raise(logic [31:0] x, logic [4:0] e);
    logic [31:0] r;
    r = 32'd1;
    for (int i = 0; i < e; i++) r = r * x;
    return r;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t   res;
    int          s;
    int          pos;
    int          cnt;
    logic [31:0] sum;
    res.value  = '0;
    res.status = ST_OK;
    s = find_slot(it.poly_name);
    case (op_e'(it.operation))
      OP_CREATE: begin
        if (s >= 0) begin
          count_q[s] = 0;
        end else begin
          res.status = ST_NAMES_FULL;
          for (int f = 0; f < NumPolys; f++) begin
            if (!used_q[f]) begin
              used_q[f]  = 1'b1;
              name_q[f]  = it.poly_name;
              count_q[f] = 0;
              res.status = ST_OK;
              break;
            end
          end
        end
      end
      OP_ADD: begin
        if (s < 0) begin
          res.status = ST_UNDEF;
        end else begin
          cnt = count_q[s];
          pos = 0;
          while (pos < cnt && expo_q[s][pos] > it.term_expo) pos++;
          if (pos < cnt && expo_q[s][pos] == it.term_expo) begin
            sum = coef_q[s][pos] + it.term_coef;
            coef_q[s][pos] = sum;
            if (sum == 0) begin
              for (int k = pos; k + 1 < cnt; k++) begin
                coef_q[s][k] = coef_q[s][k+1];
                expo_q[s][k] = expo_q[s][k+1];
              end
              count_q[s] = cnt - 1;
            end
          end else if (cnt >= MaxTerms) begin
            res.status = ST_TERMS_FULL;
          end else begin
            for (int k = cnt; k > pos; k--) begin
              coef_q[s][k] = coef_q[s][k-1];
              expo_q[s][k] = expo_q[s][k-1];
            end
            coef_q[s][pos] = it.term_coef;
            expo_q[s][pos] = it.term_expo;
            count_q[s] = cnt + 1;
          end
        end
      end
      OP_EVAL: begin
        if (s < 0) begin
          res.status = ST_UNDEF;
        end else begin
          for (int k = 0; k < count_q[s]; k++) begin
            res.value = res.value +
                        coef_q[s][k] * raise(it.eval_point, expo_q[s][k]);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int s = 0; s < NumPolys; s++) begin
      name_q[s]  = '0;
      used_q[s]  = 1'b0;
      count_q[s] = 0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.value, '0);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.value !== want.value)
            report_mismatch("value", out_data_i.value, want.value);
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
        end
      end
      if (in_valid_i && in_ready_i) due_results = {due_results, apply_item(in_data_i)};
      pending_o = due_results.size();
    end
  end

endmodule

// ----- sim/sparse_polynomial_store_eval_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_polynomial_store_eval_core_tb
// Drives create, add, evaluate and no-op items into the polynomial store with random
// gaps and result stalls, including a long result hold-off and a drain pause,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module sparse_polynomial_store_eval_core_tb;
  import spse_pkg::*;

  localparam int CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   calm_phase = 1'b0;
  bit   hold_off = 1'b0;
  logic [7:0] names [6];

  spse_if #(.payload_t(in_item_t))  in_if ();
  spse_if #(.payload_t(out_item_t)) out_if ();

  sparse_polynomial_store_eval_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  sparse_polynomial_store_eval_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[sparse_polynomial_store_eval_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_if.ready <= 1'b0;
    else out_if.ready <= calm_phase || ($urandom_range(99) >= 30);
  end

  task automatic send(logic [1:0] op, logic [7:0] nm, logic [31:0] coef,
                      logic [4:0] expo, logic [31:0] x);
    in_item_t it;
    it = '{operation: op, poly_name: nm, term_coef: coef, term_expo: expo,
           eval_point: x};
    while (!calm_phase && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(bit noisy);
    logic [1:0] op;
    logic [7:0] nm;
    int r;
    r  = $urandom_range(99);
    op = (r < 12) ? OP_CREATE : (r < 65) ? OP_ADD : (r < 97) ? OP_EVAL : OP_NONE;
    nm = noisy ? 8'($urandom) : names[$urandom_range(5)];
    send(op, nm, rand_word(), ($urandom_range(3) == 0) ? 5'($urandom) :
         5'($urandom_range(6)), rand_word());
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    names = '{8'h00, 8'hff, 8'h41, 8'h42, 8'h5a, 8'h7e};
    send(OP_EVAL, 8'h41, '0, '0, 32'd5);
    send(OP_ADD, 8'h41, 32'd1, 5'd0, '0);
    send(OP_CREATE, 8'h41, '0, '0, '0);
    send(OP_EVAL, 8'h41, '0, '0, 32'd7);
    send(OP_ADD, 8'h41, 32'd3, 5'd0, '0);
    send(OP_ADD, 8'h41, 32'h7fff_ffff, 5'd31, '0);
    send(OP_ADD, 8'h41, 32'd0, 5'd4, '0);
    send(OP_ADD, 8'h41, 32'h8000_0000, 5'd2, '0);
    send(OP_ADD, 8'h41, 32'h8000_0000, 5'd2, '0);
    send(OP_EVAL, 8'h41, '0, '0, 32'd0);
    send(OP_EVAL, 8'h41, '0, '0, 32'hffff_ffff);
    send(OP_ADD, 8'h41, 32'hffff_fffd, 5'd0, '0);
    send(OP_EVAL, 8'h41, '0, '0, 32'h8000_0000);
    send(OP_NONE, 8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    for (int e = 0; e < 17; e++) send(OP_ADD, 8'h42, 32'd0, 5'(e), '0);
    send(OP_ADD, 8'h42, 32'd5, 5'd3, '0);
    send(OP_EVAL, 8'h42, '0, '0, 32'd3);
    send(OP_CREATE, 8'h41, '0, '0, '0);
    for (int n = 0; n < 9; n++) send(OP_CREATE, 8'(8'h60 + n), '0, '0, '0);
    send(OP_CREATE, 8'h00, '0, '0, '0);
    // drain, then continue with a random mix that reuses the same names
    drain();
    repeat (20) @(posedge clk_i);
    for (int i = 0; i < 430; i++) begin
      if (i == 100) calm_phase = 1'b1;
      if (i == 160) calm_phase = 1'b0;
      if (i == 200) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 300) begin
        drain();
        repeat (10) @(posedge clk_i);
      end
      send_random($urandom_range(9) == 0);
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[sparse_polynomial_store_eval_core] OK");
    end else begin
      $display("[sparse_polynomial_store_eval_core] ERROR");
    end
    $finish;
  end

endmodule
